/* hdl/sdu_pkg.sv */
// package for the signed divider unit
// widths, pipeline depth and the item types shared between the modules
package sdu_pkg;

  localparam int unsigned DendW  = 64;
  localparam int unsigned StageW = DendW;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic        kind;
    logic [31:0] divisor;
    logic [31:0] dividend_high;
    logic [31:0] dividend_low;
  } sdu_in_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        overflow;
    logic        divide_by_zero;
  } sdu_out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [63:0] mag_n;
    logic [31:0] mag_d;
    logic        neg_n;
    logic        neg_q;
    logic        dz;
  } sdu_job_t;

endpackage

/* hdl/sdu_if.sv */
// valid/ready channel carrying one word
// depends on sdu_pkg for payload types
interface sdu_in_if;
  logic            valid;
  logic            ready;
  sdu_pkg::sdu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdu_out_if;
  logic             valid;
  logic             ready;
  sdu_pkg::sdu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sdu_front.sv */
// front end: takes a word, forms magnitudes and signs, queues the job
// depends on sdu_pkg
module sdu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdu_pkg::sdu_in_t  in_data_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output sdu_pkg::sdu_job_t job_o
);
  import sdu_pkg::*;

  logic [63:0] dend;
  logic [31:0] dsor;
  sdu_job_t    job;
  sdu_job_t    q_mem_q [QDepth];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  // classify
  always_comb begin
    dend = in_data_i.kind ? {in_data_i.dividend_high, in_data_i.dividend_low}
                          : {{32{in_data_i.dividend_low[31]}}, in_data_i.dividend_low};
    dsor = in_data_i.divisor;
    job.neg_n = dend[63];
    job.neg_q = dend[63] ^ dsor[31];
    job.dz    = (dsor == '0);
    job.mag_n = dend[63] ? (64'd0 - dend) : dend;
    job.mag_d = dsor[31] ? (32'd0 - dsor) : dsor;
  end

  // two-entry job queue
  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

/* hdl/sdu_back.sv */
// back end: 64-stage restoring divider pipeline, one quotient bit per stage
// depends on sdu_pkg
module sdu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  sdu_pkg::sdu_job_t job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdu_pkg::sdu_out_t out_o
);
  import sdu_pkg::*;

  // per-stage state: partial remainder, shifting dividend/quotient
  logic [32:0] rem_q   [StageW+1];
  logic [63:0] nq_q    [StageW+1];
  logic [31:0] d_q     [StageW+1];
  logic        sn_q    [StageW+1];
  logic        sq_q    [StageW+1];
  logic        dz_q    [StageW+1];
  logic        vld_q   [StageW+1];
  logic        adv;
  logic [63:0] qm;
  logic [31:0] rm;
  logic        ovf;

  // whole pipe moves when the tail is free
  assign adv         = !vld_q[StageW] || out_ready_i;
  assign job_ready_o = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= '0;
      nq_q[0]  <= job_i.mag_n;
      d_q[0]   <= job_i.mag_d;
      sn_q[0]  <= job_i.neg_n;
      sq_q[0]  <= job_i.neg_q;
      dz_q[0]  <= job_i.dz;
    end
  end

  for (genvar s = 0; s < StageW; s++) begin : g_stage
    logic [33:0] sh;
    logic [33:0] diff;
    assign sh   = {rem_q[s], nq_q[s][63]};
    assign diff = sh - {2'b00, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[s+1] <= diff[33] ? sh[32:0] : diff[32:0];
        nq_q[s+1]  <= {nq_q[s][62:0], ~diff[33]};
        d_q[s+1]   <= d_q[s];
        sn_q[s+1]  <= sn_q[s];
        sq_q[s+1]  <= sq_q[s];
        dz_q[s+1]  <= dz_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= StageW; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= job_valid_i;
      for (int i = 1; i <= StageW; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // sign fixup and flags at the tail
  always_comb begin
    qm  = nq_q[StageW];
    rm  = rem_q[StageW][31:0];
    ovf = sq_q[StageW] ? (qm > 64'h8000_0000) : (qm > 64'h7FFF_FFFF);
    out_valid_o          = vld_q[StageW];
    out_o.divide_by_zero = dz_q[StageW];
    if (dz_q[StageW]) begin
      out_o.quotient  = '0;
      out_o.remainder = '0;
      out_o.overflow  = 1'b0;
    end else begin
      out_o.quotient  = sq_q[StageW] ? (32'd0 - qm[31:0]) : qm[31:0];
      out_o.remainder = sn_q[StageW] ? (32'd0 - rm) : rm;
      out_o.overflow  = ovf;
    end
  end
endmodule

/* hdl/signed_divider_unit_core.sv */
// signed 64/32 and 32/32 divider, truncating quotient, remainder signed as dividend
// path from accept to result valid: queue entry, input stage, 64 stages
// throughput: one word per cycle while the result side accepts, set by the one-bit-per-stage divider pipeline
// reset: asynchronous active low, empties queue and pipeline valid bits
// depends on sdu_pkg, sdu_if, sdu_front, sdu_back
module signed_divider_unit_core (
  input logic  clk_i,
  input logic  rst_ni,
  sdu_in_if.sink    in_if,
  sdu_out_if.source out_if
);
  import sdu_pkg::*;

  logic     job_valid, job_ready;
  sdu_job_t job;

  sdu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_data_i   (in_if.data),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  sdu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_o       (out_if.data)
  );
endmodule

/* verif/tb_top.sv */
// self-checking bench for the signed divider unit core
// drives random and directed division words, checks results against a local predictor or the directed rows
// depends on sdu_pkg, sdu_if and signed_divider_unit_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdu_pkg::*;

  localparam int unsigned Latency = 66;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom = 450;

  localparam logic KindShort = 1'b0;
  localparam logic KindLong = 1'b1;

  typedef struct {
    sdu_in_t  op;
    logic     known;
    sdu_out_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sdu_in_if  in_if ();
  sdu_out_if out_if ();

  signed_divider_unit_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  sdu_out_t quot_q[$];
  int unsigned err_cnt;
  int unsigned idle_cycles;
  bit stim_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // predicted division result for one word
  function automatic sdu_out_t divide_word(sdu_in_t op);
    sdu_out_t res;
    logic [63:0] dend, dsor, mag_n, mag_d, qm, rm, q, r;
    logic neg_n, neg_d, neg_q;
    res = '0;
    dsor = {{32{op.divisor[31]}}, op.divisor};
    if (op.kind == KindLong) dend = {op.dividend_high, op.dividend_low};
    else dend = {{32{op.dividend_low[31]}}, op.dividend_low};
    if (op.divisor == 32'd0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    neg_n = dend[63];
    neg_d = dsor[63];
    mag_n = neg_n ? -dend : dend;
    mag_d = neg_d ? -dsor : dsor;
    qm = mag_n / mag_d;
    rm = mag_n % mag_d;
    neg_q = neg_n ^ neg_d;
    res.overflow = neg_q ? (qm > 64'h8000_0000) : (qm > 64'h7fff_ffff);
    q = neg_q ? -qm : qm;
    r = neg_n ? -rm : rm;
    res.quotient = q[31:0];
    res.remainder = r[31:0];
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 15);
      5: return -$urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic sdu_in_t rand_op();
    sdu_in_t op;
    op.kind = 1'($urandom_range(0, 1));
    op.divisor = rand_word();
    op.dividend_high = rand_word();
    op.dividend_low = rand_word();
    // keep some long divisions in range so the quotient is checked without overflow
    if (op.kind == KindLong && $urandom_range(0, 2) == 0)
      op.dividend_high = {32{op.dividend_low[31]}};
    if (op.divisor == 32'd0 && $urandom_range(0, 3) != 0) op.divisor = $urandom | 32'd1;
    return op;
  endfunction

  // send one word, waiting for the handshake
  task automatic send_word(sdu_in_t op, logic known, sdu_out_t res);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= op;
    do @(posedge clk_i); while (!in_if.ready);
    quot_q.push_back(known ? res : divide_word(op));
  endtask

  // directed rows
  dir_row_t dir_rows[$];

  task automatic add_row(logic kind, logic [31:0] dsor, logic [31:0] hi, logic [31:0] lo,
                         int known, logic [31:0] q, logic [31:0] r, int ov, int dz);
    dir_row_t row;
    row.op = '{kind: kind, divisor: dsor, dividend_high: hi, dividend_low: lo};
    row.known = known[0];
    row.res = '{quotient: q, remainder: r, overflow: ov[0], divide_by_zero: dz[0]};
    dir_rows.push_back(row);
  endtask

  // stimulus
  initial begin
    sdu_in_t op;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(KindShort, 32'd0, 32'hffff_ffff, 32'd1234, 1, 0, 0, 0, 1);
    add_row(KindLong, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 1, 0, 0, 0, 1);
    add_row(KindShort, 32'hffff_ffff, 32'd0, 32'h8000_0000, 1, 32'h8000_0000, 0, 1, 0);
    add_row(KindLong, 32'hffff_ffff, 32'h8000_0000, 32'd0, 1, 32'd0, 32'd0, 1, 0);
    add_row(KindShort, 32'd7, 32'hdead_beef, 32'd100, 1, 32'd14, 32'd2, 0, 0);
    add_row(KindShort, 32'd7, 32'd0, -32'sd100, 1, -32'sd14, -32'sd2, 0, 0);
    add_row(KindShort, -32'sd7, 32'd0, 32'd100, 1, -32'sd14, 32'd2, 0, 0);
    add_row(KindShort, -32'sd7, 32'd0, -32'sd100, 1, 32'd14, -32'sd2, 0, 0);
    add_row(KindShort, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff, 0, 0, 0);
    add_row(KindShort, 32'h8000_0000, 32'd0, 32'h8000_0000, 1, 32'd1, 0, 0, 0);
    add_row(KindShort, 32'h7fff_ffff, 32'd0, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(KindLong, 32'd1, 32'h0000_0001, 32'd0, 1, 32'd0, 32'd0, 1, 0);
    add_row(KindLong, 32'd2, 32'h0000_0000, 32'hffff_ffff, 1, 32'h7fff_ffff, 32'd1, 0, 0);
    add_row(KindLong, -32'sd1, 32'd0, 32'h8000_0000, 1, 32'h8000_0000, 32'd0, 0, 0);
    add_row(KindLong, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0, 0, 0);
    add_row(KindLong, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 0, 0, 0, 0, 0);
    add_row(KindLong, 32'h8000_0000, 32'hc000_0000, 32'd0, 0, 0, 0, 0, 0);
    add_row(KindLong, 32'd3, 32'hffff_ffff, 32'hffff_fff0, 0, 0, 0, 0, 0);
    add_row(KindLong, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0, 0);
    add_row(KindShort, 32'h8000_0000, 32'd0, 32'h7fff_ffff, 0, 0, 0, 0, 0);

    foreach (dir_rows[i]) send_word(dir_rows[i].op, dir_rows[i].known, dir_rows[i].res);

    // hold off until the pipeline is empty
    in_if.valid <= 1'b0;
    while (quot_q.size() != 0) @(posedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      op = rand_op();
      send_word(op, 1'b0, '0);
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side stalls
  initial begin
    int unsigned g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_if.ready <= 1'b0;
        repeat (g + 1) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    sdu_out_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (quot_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_if.data);
        err_cnt++;
      end else begin
        exp_w = quot_q.pop_front();
        if (out_if.data.quotient !== exp_w.quotient) begin
          $display("%0t: quotient exp %h got %h", $time, exp_w.quotient, out_if.data.quotient);
          err_cnt++;
        end
        if (out_if.data.remainder !== exp_w.remainder) begin
          $display("%0t: remainder exp %h got %h", $time, exp_w.remainder,
                   out_if.data.remainder);
          err_cnt++;
        end
        if (out_if.data.overflow !== exp_w.overflow) begin
          $display("%0t: overflow exp %b got %b", $time, exp_w.overflow, out_if.data.overflow);
          err_cnt++;
        end
        if (out_if.data.divide_by_zero !== exp_w.divide_by_zero) begin
          $display("%0t: divide_by_zero exp %b got %b", $time, exp_w.divide_by_zero,
                   out_if.data.divide_by_zero);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired with %0d results pending", $time, quot_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (quot_q.size() != 0 && idle_cycles < WatchLimit) @(posedge clk_i);
    if (quot_q.size() == 0) begin
      repeat (Latency + 10) @(posedge clk_i);
      if (err_cnt == 0 && quot_q.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end else begin
      $display("%0t: timeout with %0d results pending", $time, quot_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
